/* hdl/ttl_pkg.sv */
`default_nettype none

package ttl_pkg;

  // Fixed geometry of the tiled source format.
  localparam int unsigned LANES = 4;

  // Register map, indexed by paddr[3:2].
  typedef enum logic [1:0] {
    REG_PLANE_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_LINE_PITCH   = 2'd3
  } reg_idx_e;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic        plane_mode;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [13:0] line_pitch;
  } cfg_t;

  // Position of one source word, registered after the address multiply.
  typedef struct packed {
    logic [25:0] product;
    logic [11:0] col_base;
    logic [1:0]  word;
    logic        live;
    logic        last;
    logic        mode;
  } pos_t;

  // What one lane contributes from its two source bytes.
  typedef struct packed {
    logic [15:0] copy;
    logic [7:0]  cb;
    logic [7:0]  cr;
  } lane_t;

endpackage

`default_nettype wire

/* hdl/ttl_in_if.sv */
`default_nettype none

interface ttl_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] source_word;

  modport source (output valid, output source_word, input ready);
  modport sink (input valid, input source_word, output ready);
endinterface

`default_nettype wire

/* hdl/ttl_out_if.sv */
`default_nettype none

interface ttl_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] write_offset;
  logic [63:0] first_plane_bytes;
  logic [31:0] second_plane_bytes;
  logic [3:0]  byte_count;
  logic        frame_done;

  modport source (output valid, output write_offset, output first_plane_bytes,
                  output second_plane_bytes, output byte_count, output frame_done,
                  input ready);
  modport sink (input valid, input write_offset, input first_plane_bytes,
                input second_plane_bytes, input byte_count, input frame_done,
                output ready);
endinterface

`default_nettype wire

/* hdl/tiled_32x32_to_linear_planes.sv */
`default_nettype none

// Detiler for a 32x32-tiled picture plane. Each accepted 64-bit source word,
// in tiled source order, yields one linear destination write: offset, plane
// bytes, byte count and a frame-end flag. The block takes one word per clock
// cycle unless the output stalls: the first stage steps the position
// counters and forms the picture line number times the pitch in one 12x14
// multiplier, the second adds the column and word offset while four byte-pair
// lanes copy or split the CbCr bytes into the output register. Configuration
// is written over the APB port at byte addresses 0, 4, 8 and 12 and should
// change only between frames.
module tiled_32x32_to_linear_planes #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ttl_in_if.sink           in_i,
  ttl_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ttl_pkg::*;

  cfg_t        cfg_q;
  pos_t        pos;
  lane_t       lanes [LANES];
  logic        cfg_wr;
  logic        s1_v_q, s1_v_d;
  logic [63:0] s1_word_q;
  logic        out_v_q, out_v_d;
  logic        in_acc, s1_ready, s2_load;
  logic [4:0]  word_off;
  logic [25:0] offset_d, offset_q;
  logic [63:0] first_d, first_q;
  logic [31:0] second_d, second_q;
  logic [3:0]  count_d, count_q;
  logic        done_q;

  // Register writes complete in the access phase; there are no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_mode   <= 1'b0;
      cfg_q.frame_width  <= 13'd1920;
      cfg_q.frame_height <= 13'd1088;
      cfg_q.line_pitch   <= 14'd1920;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_PLANE_MODE:   cfg_q.plane_mode   <= pwdata[0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[12:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[12:0];
        REG_LINE_PITCH:   cfg_q.line_pitch   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_PLANE_MODE:   prdata = {31'd0, cfg_q.plane_mode};
      REG_FRAME_WIDTH:  prdata = {19'd0, cfg_q.frame_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, cfg_q.frame_height};
      REG_LINE_PITCH:   prdata = {18'd0, cfg_q.line_pitch};
      default:          prdata = 32'd0;
    endcase
  end

  // Two-stage pipeline; each stage loads when the one after it can move.
  assign s2_load  = s1_v_q && (!out_v_q || out_o.ready);
  assign s1_ready = !s1_v_q || s2_load;
  assign in_acc   = in_i.valid && s1_ready;
  assign in_i.ready = s1_ready;

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc) begin
      s1_v_d = 1'b1;
    end else if (s2_load) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (s2_load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_i.source_word;
    end
  end

  // Position counters and the line-times-pitch product.
  ttl_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .adv_i  (in_acc),
    .pos_o  (pos)
  );

  // One lane per pair of source bytes.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ttl_lane u_lane (
      .mode_i (pos.mode),
      .live_i (pos.live),
      .pair_i (s1_word_q[16*g +: 16]),
      .lane_o (lanes[g])
    );
  end

  // Merge the lanes and finish the destination offset.
  always_comb begin
    word_off = pos.mode ? {1'b0, pos.word, 2'b00} : {pos.word, 3'b000};
    offset_d = pos.live ? (pos.product + 26'(pos.col_base) + 26'(word_off)) : 26'd0;
    first_d  = {lanes[3].copy, lanes[2].copy, lanes[1].copy, lanes[0].copy}
             | {32'd0, lanes[3].cb, lanes[2].cb, lanes[1].cb, lanes[0].cb};
    second_d = {lanes[3].cr, lanes[2].cr, lanes[1].cr, lanes[0].cr};
    count_d  = !pos.live ? 4'd0 : (pos.mode ? 4'd4 : 4'd8);
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      offset_q <= offset_d;
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
      done_q   <= pos.last;
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.write_offset       = offset_q;
  assign out_o.first_plane_bytes  = first_q;
  assign out_o.second_plane_bytes = second_q;
  assign out_o.byte_count         = count_q;
  assign out_o.frame_done         = done_q;

endmodule

`default_nettype wire

/* hdl/ttl_lane.sv */
`default_nettype none

module ttl_lane (
  input  wire logic           mode_i,
  input  wire logic           live_i,
  input  wire logic [15:0]    pair_i,
  output ttl_pkg::lane_t      lane_o
);
  import ttl_pkg::*;

  // Copy mode passes both bytes; chroma mode splits them into Cb and Cr.
  always_comb begin
    lane_o.copy = (live_i && !mode_i) ? pair_i : 16'd0;
    lane_o.cb   = (live_i && mode_i) ? pair_i[7:0] : 8'd0;
    lane_o.cr   = (live_i && mode_i) ? pair_i[15:8] : 8'd0;
  end

endmodule

`default_nettype wire

/* hdl/ttl_addr.sv */
`default_nettype none

module ttl_addr #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ttl_pkg::cfg_t cfg_i,
  input  wire logic          adv_i,
  output ttl_pkg::pos_t      pos_o
);
  import ttl_pkg::*;

  logic [6:0]  tile_row_q, tile_row_d;
  logic [6:0]  column_pair_q, column_pair_d;
  logic [4:0]  tile_line_q, tile_line_d;
  logic [1:0]  word_in_line_q, word_in_line_d;
  pos_t        pos_q, pos_d;

  logic [13:0] width_clamp, width_eff, height_eff;
  logic [14:0] mb_cols;
  logic [9:0]  pairs;
  logic [14:0] mb_rows;
  logic [9:0]  rows;
  logic [11:0] line_no;
  logic [11:0] col_base;
  logic [13:0] half_end;
  logic        pair_end, row_end;

  // Effective plane size, clamped to the supported maximum.
  always_comb begin
    width_clamp = ({1'b0, cfg_i.frame_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH)
                                                                : {1'b0, cfg_i.frame_width};
    width_eff   = cfg_i.plane_mode ? (width_clamp >> 1) : width_clamp;
    height_eff  = ({1'b0, cfg_i.frame_height} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT)
                                                                  : {1'b0, cfg_i.frame_height};
  end

  // Column-pair and tile-row counts after macroblock rounding; zero counts as one.
  always_comb begin
    if (cfg_i.plane_mode) begin
      mb_cols = ({1'b0, width_eff} + 15'd7) >> 3;
      mb_rows = ((({1'b0, height_eff} + 15'd7) >> 3) + 15'd3) >> 2;
    end else begin
      mb_cols = ({1'b0, width_eff} + 15'd15) >> 4;
      mb_rows = ((({1'b0, height_eff} + 15'd15) >> 4) + 15'd1) >> 1;
    end
    pairs = 10'((mb_cols + 15'd1) >> 1);
    rows  = 10'(mb_rows);
    if (pairs == 10'd0) begin
      pairs = 10'd1;
    end
    if (rows == 10'd0) begin
      rows = 10'd1;
    end
  end

  // Current position and what part of the line is inside the picture.
  always_comb begin
    line_no  = {tile_row_q, tile_line_q};
    col_base = cfg_i.plane_mode ? {1'b0, column_pair_q, 4'd0} : {column_pair_q, 5'd0};
    half_end = {2'b0, col_base} + (cfg_i.plane_mode ? 14'd8 : 14'd16);
    pair_end = ({3'b0, column_pair_q} + 10'd1) >= pairs;
    row_end  = ({3'b0, tile_row_q} + 10'd1) >= rows;

    pos_d.product  = {14'd0, line_no} * {12'd0, cfg_i.line_pitch};
    pos_d.col_base = col_base;
    pos_d.word     = word_in_line_q;
    pos_d.mode     = cfg_i.plane_mode;
    pos_d.live     = 1'b0;
    if ({2'b0, line_no} < height_eff) begin
      if (half_end < width_eff) begin
        pos_d.live = 1'b1;
      end else if ({2'b0, col_base} < width_eff) begin
        pos_d.live = !word_in_line_q[1];
      end
    end
    pos_d.last = (word_in_line_q == 2'd3) && (tile_line_q == 5'd31) && pair_end && row_end;
  end

  // Source-order counters: word, line, column pair, tile row.
  always_comb begin
    word_in_line_d = word_in_line_q + 2'd1;
    tile_line_d    = tile_line_q;
    column_pair_d  = column_pair_q;
    tile_row_d     = tile_row_q;
    if (word_in_line_q == 2'd3) begin
      tile_line_d = tile_line_q + 5'd1;
      if (tile_line_q == 5'd31) begin
        if (pair_end) begin
          column_pair_d = 7'd0;
          tile_row_d    = row_end ? 7'd0 : tile_row_q + 7'd1;
        end else begin
          column_pair_d = column_pair_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_row_q     <= '0;
      column_pair_q  <= '0;
      tile_line_q    <= '0;
      word_in_line_q <= '0;
    end else if (adv_i) begin
      tile_row_q     <= tile_row_d;
      column_pair_q  <= column_pair_d;
      tile_line_q    <= tile_line_d;
      word_in_line_q <= word_in_line_d;
    end
  end

  // Position register; only valid alongside the stage valid held above.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

`default_nettype wire
